// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, clocked and disabled during reset.
`define RRTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Overlapping implication, clocked and disabled during reset.
`define RRTS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   `RRTS_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/rrts_pkg.sv =====
// Types, codes and sizes for the round-robin thread scheduler.
// No dependencies; imported by rrts_scan, the top level and the bench.
`timescale 1ns / 1ps

package rrts_pkg;

   localparam int MAX_THREADS = 16;
   localparam int TID_W       = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);
   localparam int TICK_W      = 31;
   localparam int KIND_W      = 3;
   localparam int OUT_TID_W   = 4;

   typedef enum logic [1:0] {
      TS_READY    = 2'd0,
      TS_RUNNING  = 2'd1,
      TS_SLEEPING = 2'd2,
      TS_DEAD     = 2'd3
   } tstate_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_YIELD = 3'd0,
      KIND_SLEEP = 3'd1,
      KIND_EXIT  = 3'd2,
      KIND_CREATE = 3'd3,
      KIND_ENTER = 3'd4,
      KIND_LEAVE = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_READY = 2'd2,
      STATUS_CRITICAL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_APPLY,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      logic              start;
      logic [TID_W-1:0]  cur;
      logic [CNT_W-1:0]  count;
      logic [TICK_W-1:0] now;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic [TID_W-1:0] chosen;
      logic             rd_en;
      logic [TID_W-1:0] rd_addr;
      logic             wr_en;
      logic [TID_W-1:0] wr_addr;
      tstate_type       wr_state;
   } scan_rsp_type;

endpackage

// ===== rtl/core/rrts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rrts_scan.sv =====
// Switch pass: walks the thread table in round-robin order, wakes due sleepers,
// demotes the running thread and finds the next ready one. Uses rrts_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrts_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  rrts_pkg::scan_req_type        scan_req,
   input  logic [1:0]                    rd_state,
   input  logic [rrts_pkg::TICK_W-1:0]   rd_wake,
   output rrts_pkg::scan_rsp_type        scan_rsp
);

   import rrts_pkg::*;

   logic             busy_ff,       busy_in;
   logic [CNT_W-1:0] issue_cnt_ff,  issue_cnt_in;
   logic [TID_W-1:0] issue_addr_ff, issue_addr_in;
   logic             proc_valid_ff, proc_valid_in;
   logic [TID_W-1:0] proc_addr_ff,  proc_addr_in;
   logic             found_ff,      found_in;
   logic [TID_W-1:0] chosen_ff,     chosen_in;

   logic             issue_go;
   logic             done;
   tstate_type       old_st;
   tstate_type       new_st;

   function automatic logic [TID_W-1:0] wrap_inc(input logic [TID_W-1:0] a,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(a) + CNT_W'(1);
      wrap_inc = (nxt >= n) ? '0 : nxt[TID_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         issue_cnt_ff  <= '0;
         issue_addr_ff <= '0;
         proc_valid_ff <= 1'b0;
         proc_addr_ff  <= '0;
         found_ff      <= 1'b0;
         chosen_ff     <= '0;
      end else begin
         busy_ff       <= busy_in;
         issue_cnt_ff  <= issue_cnt_in;
         issue_addr_ff <= issue_addr_in;
         proc_valid_ff <= proc_valid_in;
         proc_addr_ff  <= proc_addr_in;
         found_ff      <= found_in;
         chosen_ff     <= chosen_in;
      end
   end

   always_comb begin
      issue_go = busy_ff && (issue_cnt_ff < scan_req.count);
      done     = busy_ff && !issue_go && !proc_valid_ff;

      // demote the running current thread, wake a due sleeper
      old_st = tstate_type'(rd_state);
      new_st = old_st;
      if (proc_addr_ff == scan_req.cur && old_st == TS_RUNNING) begin
         new_st = TS_READY;
      end else if (old_st == TS_SLEEPING && rd_wake <= scan_req.now) begin
         new_st = TS_READY;
      end

      busy_in       = busy_ff && !done;
      issue_cnt_in  = issue_cnt_ff;
      issue_addr_in = issue_addr_ff;
      proc_valid_in = issue_go;
      proc_addr_in  = issue_addr_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;

      if (issue_go) begin
         issue_cnt_in  = issue_cnt_ff + CNT_W'(1);
         issue_addr_in = wrap_inc(issue_addr_ff, scan_req.count);
      end

      // first ready entry in walk order wins
      if (proc_valid_ff && new_st == TS_READY && !found_ff) begin
         found_in  = 1'b1;
         chosen_in = proc_addr_ff;
      end

      if (scan_req.start && !busy_ff) begin
         busy_in       = 1'b1;
         issue_cnt_in  = '0;
         issue_addr_in = wrap_inc(scan_req.cur, scan_req.count);
         proc_valid_in = 1'b0;
         found_in      = 1'b0;
      end

      scan_rsp.done     = done;
      scan_rsp.found    = found_ff;
      scan_rsp.chosen   = chosen_ff;
      scan_rsp.rd_en    = issue_go;
      scan_rsp.rd_addr  = issue_addr_ff;
      scan_rsp.wr_en    = proc_valid_ff && (new_st != old_st);
      scan_rsp.wr_addr  = proc_addr_ff;
      scan_rsp.wr_state = new_st;
   end

   `RRTS_ASSERT_IMP(a_proc_in_table, clock, reset, proc_valid_ff,
                    CNT_W'(proc_addr_ff) < scan_req.count, "entry outside the table")
   `RRTS_ASSERT_IMP(a_chosen_in_table, clock, reset, found_ff,
                    CNT_W'(chosen_ff) < scan_req.count, "chosen thread outside the table")
   `RRTS_ASSERT_IMP(a_done_idle, clock, reset, done, !proc_valid_ff && !issue_go,
                    "pass ended with beats in flight")

endmodule

// ===== rtl/core/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler with per-thread sleep timers.
// Items with no switch give their result from the apply state; a switch first
// runs a pass over the table, one entry a cycle, and gives it from the finish state.
// A new item is taken only while idle; busy stays high until the result cycle.
// Reset clears count, current thread and critical flag; table RAMs hold junk
// until written, and no result is ever held off by the receiver.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module round_robin_thread_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [rrts_pkg::KIND_W-1:0]      req_kind,
   input  logic [rrts_pkg::TICK_W-1:0]      req_now_tick,
   input  logic [rrts_pkg::TICK_W-1:0]      req_sleep_ticks,
   output logic                             rsp_valid,
   output logic [rrts_pkg::OUT_TID_W-1:0]   rsp_running_thread,
   output logic [rrts_pkg::OUT_TID_W-1:0]   rsp_new_thread,
   output logic [1:0]                       rsp_status
);

   import rrts_pkg::*;

   fsm_type               fsm_ff,     fsm_in;
   logic [CNT_W-1:0]      count_ff,   count_in;
   logic [TID_W-1:0]      current_ff, current_in;
   logic                  crit_ff,    crit_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [TICK_W-1:0]     now_ff;
   logic [TICK_W-1:0]     ticks_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_TID_W-1:0]  rsp_run_ff,   rsp_run_in;
   logic [OUT_TID_W-1:0]  rsp_new_ff,   rsp_new_in;
   status_type            rsp_stat_ff,  rsp_stat_in;

   logic                  accept;
   logic [TICK_W:0]       wake_sum;
   logic [TICK_W-1:0]     wake_sat;

   logic                  st_wr_en;
   logic [TID_W-1:0]      st_wr_addr;
   tstate_type            st_wr_data;
   logic [1:0]            st_rd_data;
   logic                  wk_wr_en;
   logic [TICK_W-1:0]     wk_rd_data;

   scan_req_type          scan_req;
   scan_rsp_type          scan_rsp;

   assign accept = start && !busy;
   assign busy   = (fsm_ff != FSM_IDLE);

   // saturating deadline
   assign wake_sum = {1'b0, now_ff} + {1'b0, ticks_ff};
   assign wake_sat = wake_sum[TICK_W] ? '1 : wake_sum[TICK_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         count_ff     <= '0;
         current_ff   <= '0;
         crit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         current_ff   <= current_in;
         crit_ff      <= crit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         now_ff   <= req_now_tick;
         ticks_ff <= req_sleep_ticks;
      end
      rsp_run_ff  <= rsp_run_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      fsm_in       = fsm_ff;
      count_in     = count_ff;
      current_in   = current_ff;
      crit_in      = crit_ff;
      rsp_valid_in = 1'b0;
      rsp_run_in   = rsp_run_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_stat_in  = rsp_stat_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = current_ff;
      st_wr_data   = TS_READY;
      wk_wr_en     = 1'b0;

      scan_req.start = 1'b0;
      scan_req.cur   = current_ff;
      scan_req.count = count_ff;
      scan_req.now   = now_ff;

      case (fsm_ff)
         FSM_IDLE: begin
            if (accept) begin
               fsm_in = FSM_APPLY;
            end
         end
         FSM_APPLY: begin
            fsm_in       = FSM_IDLE;
            rsp_valid_in = 1'b1;
            rsp_new_in   = '0;
            rsp_stat_in  = STATUS_OK;
            case (kind_ff)
               KIND_YIELD, KIND_SLEEP, KIND_EXIT: begin
                  if (count_ff == '0) begin
                     rsp_stat_in = STATUS_NO_READY;
                  end else begin
                     if (kind_ff == KIND_SLEEP) begin
                        st_wr_en   = 1'b1;
                        st_wr_data = TS_SLEEPING;
                        wk_wr_en   = 1'b1;
                     end else if (kind_ff == KIND_EXIT) begin
                        st_wr_en   = 1'b1;
                        st_wr_data = TS_DEAD;
                     end
                     if (crit_ff) begin
                        rsp_stat_in = STATUS_CRITICAL;
                     end else begin
                        // hold the result until the pass is through
                        rsp_valid_in   = 1'b0;
                        scan_req.start = 1'b1;
                        fsm_in         = FSM_SCAN;
                     end
                  end
               end
               KIND_CREATE: begin
                  if (count_ff >= CNT_W'(MAX_THREADS)) begin
                     rsp_stat_in = STATUS_FULL;
                  end else begin
                     st_wr_en   = 1'b1;
                     st_wr_addr = count_ff[TID_W-1:0];
                     st_wr_data = (count_ff == '0) ? TS_RUNNING : TS_READY;
                     rsp_new_in = OUT_TID_W'(count_ff);
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               KIND_ENTER: begin
                  crit_in = 1'b1;
               end
               KIND_LEAVE: begin
                  crit_in = 1'b0;
               end
               default: begin
               end
            endcase
            rsp_run_in = OUT_TID_W'(current_ff);
         end
         FSM_SCAN: begin
            st_wr_en   = scan_rsp.wr_en;
            st_wr_addr = scan_rsp.wr_addr;
            st_wr_data = scan_rsp.wr_state;
            if (scan_rsp.done) begin
               fsm_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            fsm_in       = FSM_IDLE;
            rsp_valid_in = 1'b1;
            rsp_new_in   = '0;
            if (scan_rsp.found) begin
               st_wr_en    = 1'b1;
               st_wr_addr  = scan_rsp.chosen;
               st_wr_data  = TS_RUNNING;
               current_in  = scan_rsp.chosen;
               rsp_stat_in = STATUS_OK;
               rsp_run_in  = OUT_TID_W'(scan_rsp.chosen);
            end else begin
               rsp_stat_in = STATUS_NO_READY;
               rsp_run_in  = OUT_TID_W'(current_ff);
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   rrts_ram #(
      .WIDTH (2),
      .DEPTH (MAX_THREADS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (scan_rsp.rd_en),
      .rd_addr (scan_rsp.rd_addr),
      .rd_data (st_rd_data)
   );

   rrts_ram #(
      .WIDTH (TICK_W),
      .DEPTH (MAX_THREADS)
   ) u_wake_ram (
      .clock   (clock),
      .wr_en   (wk_wr_en),
      .wr_addr (current_ff),
      .wr_data (wake_sat),
      .rd_en   (scan_rsp.rd_en),
      .rd_addr (scan_rsp.rd_addr),
      .rd_data (wk_rd_data)
   );

   rrts_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .rd_state (st_rd_data),
      .rd_wake  (wk_rd_data),
      .scan_rsp (scan_rsp)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_thread = rsp_run_ff;
   assign rsp_new_thread     = rsp_new_ff;
   assign rsp_status         = rsp_stat_ff;

   `RRTS_ASSERT_IMP(a_current_in_table, clock, reset, count_ff != '0,
                    CNT_W'(current_ff) < count_ff, "current thread outside the table")
   `RRTS_ASSERT_IMP(a_no_write_idle, clock, reset, fsm_ff == FSM_IDLE,
                    !st_wr_en && !wk_wr_en, "table written while idle")
   `RRTS_ASSERT_IMP(a_beat_after_work, clock, reset, rsp_valid_ff,
                    $past(busy), "result beat without work")

endmodule

// ===== tb/sv/round_robin_thread_scheduler_test.sv =====
// Self-checking bench for the round-robin thread scheduler: directed events, then random ones.
// The scheduler state is tracked in the bench, and every result strobe is compared with it.
// Depends on rrts_pkg and the round_robin_thread_scheduler RTL only.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_test;
   import rrts_pkg::*;

   localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;
   localparam logic [TICK_W-1:0] TICK_TOP    = '1;
   localparam int                RANDOM_BEATS = 1250;
   localparam int                PRINT_CAP    = 40;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] ticks;
   } event_beat_type;

   typedef struct {
      logic [OUT_TID_W-1:0] running;
      logic [OUT_TID_W-1:0] new_id;
      status_type           status;
   } sched_out_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind        = '0;
   logic [TICK_W-1:0]    req_now_tick    = '0;
   logic [TICK_W-1:0]    req_sleep_ticks = '0;
   logic                 rsp_valid;
   logic [OUT_TID_W-1:0] rsp_running_thread;
   logic [OUT_TID_W-1:0] rsp_new_thread;
   logic [1:0]           rsp_status;

   // bench copy of the thread table
   tstate_type        slot_state [MAX_THREADS];
   logic [TICK_W-1:0] slot_wake  [MAX_THREADS];
   int                slot_count = 0;
   int                cur_tid    = 0;
   logic              crit       = 1'b0;

   event_beat_type pending_beats [$];
   sched_out_type  predicted_outs [$];
   int          mismatches = 0;
   int          checked    = 0;
   int          kind_tally   [8];
   int          status_tally [4];
   int          burst_left = 5;
   int          gap_left   = 0;

   round_robin_thread_scheduler uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_now_tick       (req_now_tick),
      .req_sleep_ticks    (req_sleep_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_running_thread (rsp_running_thread),
      .rsp_new_thread     (rsp_new_thread),
      .rsp_status         (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d beats pending and %0d results outstanding",
               pending_beats.size(), predicted_outs.size());
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("%0t: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Demote, wake due sleepers, then pick the next ready slot after the current one.
   function automatic status_type reschedule(input logic [TICK_W-1:0] now);
      int i;
      int idx;
      if (cur_tid < slot_count && slot_state[cur_tid] == TS_RUNNING)
         slot_state[cur_tid] = TS_READY;
      for (i = 0; i < slot_count; i++) begin
         if (slot_state[i] == TS_SLEEPING && slot_wake[i] <= now)
            slot_state[i] = TS_READY;
      end
      idx = cur_tid;
      for (i = 0; i < slot_count; i++) begin
         idx++;
         if (idx >= slot_count)
            idx = 0;
         if (slot_state[idx] == TS_READY) begin
            cur_tid = idx;
            slot_state[idx] = TS_RUNNING;
            return STATUS_OK;
         end
      end
      return STATUS_NO_READY;
   endfunction

   function automatic sched_out_type schedule_event(input event_beat_type beat);
      sched_out_type   res;
      logic [TICK_W:0] deadline;
      res.new_id = '0;
      res.status = STATUS_OK;
      case (beat.kind)
         KIND_YIELD, KIND_SLEEP, KIND_EXIT: begin
            if (slot_count == 0 || cur_tid >= slot_count) begin
               res.status = STATUS_NO_READY;
            end else begin
               if (beat.kind == KIND_SLEEP) begin
                  deadline = {1'b0, beat.now} + {1'b0, beat.ticks};
                  slot_wake[cur_tid]  = deadline[TICK_W] ? TICK_TOP : deadline[TICK_W-1:0];
                  slot_state[cur_tid] = TS_SLEEPING;
               end else if (beat.kind == KIND_EXIT) begin
                  slot_state[cur_tid] = TS_DEAD;
               end
               res.status = crit ? STATUS_CRITICAL : reschedule(beat.now);
            end
         end
         KIND_CREATE: begin
            if (slot_count >= MAX_THREADS) begin
               res.status = STATUS_FULL;
            end else begin
               res.new_id = slot_count[OUT_TID_W-1:0];
               slot_state[slot_count] = TS_READY;
               if (slot_count == 0) begin
                  slot_state[0] = TS_RUNNING;
                  cur_tid = 0;
               end
               slot_count++;
            end
         end
         KIND_ENTER: crit = 1'b1;
         KIND_LEAVE: crit = 1'b0;
         default: ;
      endcase
      res.running = cur_tid[OUT_TID_W-1:0];
      return res;
   endfunction

   task automatic add_beat(input logic [KIND_W-1:0] kind, input logic [TICK_W-1:0] now,
                           input logic [TICK_W-1:0] ticks);
      event_beat_type beat;
      beat.kind  = kind;
      beat.now   = now;
      beat.ticks = ticks;
      pending_beats.insert(pending_beats.size(), beat);
   endtask

   // driver: present beats in bursts, idle between them
   always @(posedge clock) begin : drive_events
      event_beat_type beat;
      logic           fire;
      fire = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (fire) begin
            beat = pending_beats.pop_front();
            predicted_outs.insert(predicted_outs.size(), schedule_event(beat));
            kind_tally[beat.kind]++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
         if (!start || fire) begin
            if (gap_left == 0 && pending_beats.size() != 0) begin
               start           <= 1'b1;
               req_kind        <= pending_beats[0].kind;
               req_now_tick    <= pending_beats[0].now;
               req_sleep_ticks <= pending_beats[0].ticks;
            end else begin
               if (gap_left > 0)
                  gap_left--;
               // junk on the request fields while idle
               start           <= 1'b0;
               req_kind        <= KIND_W'($urandom_range(0, 7));
               req_now_tick    <= TICK_W'($urandom());
               req_sleep_ticks <= TICK_W'($urandom());
            end
         end
      end
   end

   // monitor: every strobe must match the oldest prediction
   always @(posedge clock) begin : check_results
      sched_out_type want;
      if (!reset && rsp_valid) begin
         if (predicted_outs.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding (run %0d new %0d st %0d)",
                                      rsp_running_thread, rsp_new_thread, rsp_status));
         end else begin
            want = predicted_outs.pop_front();
            checked++;
            status_tally[rsp_status]++;
            if (rsp_running_thread !== want.running)
               report_mismatch($sformatf("running_thread %0d, wanted %0d",
                                         rsp_running_thread, want.running));
            if (rsp_new_thread !== want.new_id)
               report_mismatch($sformatf("new_thread %0d, wanted %0d",
                                         rsp_new_thread, want.new_id));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %s", rsp_status,
                                         want.status.name()));
         end
      end
   end

   initial begin : stimulus
      logic [TICK_W-1:0] base;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] ticks;
      logic [KIND_W-1:0] kind;
      int                roll;
      int                n;

      // empty table, critical around an empty yield, reserved kinds
      add_beat(KIND_YIELD, 0, 0);
      add_beat(KIND_SLEEP, TICK_TOP, TICK_TOP);
      add_beat(KIND_EXIT, 0, TICK_TOP);
      add_beat(KIND_ENTER, TICK_TOP, 0);
      add_beat(KIND_YIELD, 7, 7);
      add_beat(KIND_LEAVE, 0, 0);
      add_beat(KIND_RSVD_A, TICK_TOP, TICK_TOP);
      add_beat(KIND_RSVD_B, 0, 0);
      add_beat(KIND_CREATE, 0, 0);
      add_beat(KIND_CREATE, 0, 0);
      add_beat(KIND_CREATE, 0, 0);
      add_beat(KIND_YIELD, 0, 0);
      // saturating deadline
      add_beat(KIND_SLEEP, TICK_TOP - TICK_W'(5), TICK_TOP);
      add_beat(KIND_ENTER, 0, 0);
      add_beat(KIND_YIELD, 50, 0);
      add_beat(KIND_SLEEP, 100, 10);
      // exit of a current thread that is asleep, still in critical
      add_beat(KIND_EXIT, 100, 0);
      add_beat(KIND_LEAVE, 100, 0);
      add_beat(KIND_YIELD, 0, 0);
      // sleeper due at once comes back as the only candidate
      add_beat(KIND_SLEEP, 0, 0);
      add_beat(KIND_YIELD, TICK_TOP, 0);
      add_beat(KIND_SLEEP, 5, 1000);
      // nothing ready, then re-sleep a current that is not running
      add_beat(KIND_SLEEP, 5, 1000);
      add_beat(KIND_SLEEP, 6, 2000);
      add_beat(KIND_YIELD, 1000, 0);

      base = 1010;
      for (n = 0; n < RANDOM_BEATS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30)      kind = KIND_YIELD;
         else if (roll < 60) kind = KIND_SLEEP;
         else if (roll < 61) kind = KIND_EXIT;
         else if (roll < 76) kind = KIND_CREATE;
         else if (roll < 82) kind = KIND_ENTER;
         else if (roll < 96) kind = KIND_LEAVE;
         else if (roll < 98) kind = KIND_RSVD_A;
         else                kind = KIND_RSVD_B;
         base = base + TICK_W'($urandom_range(0, 50));
         roll = $urandom_range(0, 39);
         if (roll < 2)       now = TICK_W'($urandom());
         else if (roll == 2) now = TICK_TOP;
         else                now = base;
         roll = $urandom_range(0, 39);
         if (roll < 2)       ticks = TICK_W'($urandom());
         else if (roll == 2) ticks = TICK_TOP;
         else                ticks = TICK_W'($urandom_range(0, 300));
         add_beat(kind, now, ticks);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0 || predicted_outs.size() != 0)
         @(posedge clock);
      // catch any stray strobe after the last expected one
      repeat (40) @(posedge clock);

      $display("Covered %0d events: %0d yield, %0d sleep, %0d exit, %0d create,",
               kind_tally.sum(), kind_tally[KIND_YIELD], kind_tally[KIND_SLEEP],
               kind_tally[KIND_EXIT], kind_tally[KIND_CREATE]);
      $display("  %0d enter, %0d leave, %0d reserved",
               kind_tally[KIND_ENTER], kind_tally[KIND_LEAVE],
               kind_tally[KIND_RSVD_A] + kind_tally[KIND_RSVD_B]);
      $display("Checked %0d results: %0d ok, %0d table full, %0d nothing ready,",
               checked, status_tally[STATUS_OK], status_tally[STATUS_FULL],
               status_tally[STATUS_NO_READY]);
      $display("  %0d held by critical; %0d mismatches",
               status_tally[STATUS_CRITICAL], mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
